// ===== rtl/dac_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dac_pkg
// Types and constants shared by the distinct address counter modules.
// ----------------------------------------------------------------------------
package dac_pkg;

  localparam int ADDR_W = 48;
  localparam int COUNT_W = 7;
  localparam int COUNT_MAX = 127;
  localparam logic signed [7:0] THRESHOLD_RESET = -8'sd80;

  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_END = 1'b1;

  localparam logic REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic opcode;
    logic [ADDR_W-1:0] device_address;
    logic signed [7:0] signal_strength;
  } dac_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] device_count;
    logic table_overflow;
  } dac_rsp_t;

  typedef struct packed {
    logic tok;
    logic hit;
  } dac_probe_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } dac_state_t;

endpackage
`default_nettype wire

// ===== rtl/dac_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dac_cell
// One table entry. Compares the probe address as the token passes through
// and hands the token and hit flag to the next cell.
// ----------------------------------------------------------------------------
module dac_cell
  import dac_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic occupied,
  input  wire logic wr_sel,
  input  wire logic [ADDR_W-1:0] probe_addr,
  input  wire dac_probe_t probe_in,
  output dac_probe_t probe_out
);

  logic [ADDR_W-1:0] entry;
  logic match;

  assign match = occupied && (entry == probe_addr);

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      entry <= probe_addr;
    end
    probe_out.hit <= probe_in.hit | match;
    if (rst) begin
      probe_out.tok <= 1'b0;
    end else begin
      probe_out.tok <= probe_in.tok;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/distinct_address_counter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// distinct_address_counter
// Counts distinct device addresses per scan window in a chain of entry cells.
// For a counted report the probe token walks the cell chain one cell per
// cycle; an unmatched address is then appended, or flags overflow if full.
// Reports below threshold and end-of-window requests need no chain scan.
// One request is processed at a time; device reports enter while a result
// waits, an end-of-window request waits for the result register to free.
// Synchronous reset clears count and flag and sets threshold to THRESHOLD_RESET.
// ----------------------------------------------------------------------------
module distinct_address_counter
  import dac_pkg::*;
#(
  parameter int MAX_DEVICES = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic req_ready,
  input  wire dac_req_t req,
  output logic rsp_valid,
  input  wire logic rsp_ready,
  output dac_rsp_t rsp,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  localparam int CW = $clog2(MAX_DEVICES + 1);

  dac_state_t state, state_next;
  logic [CW-1:0] fill_count;
  logic overflow_seen;
  logic signed [7:0] strength_threshold;
  logic [ADDR_W-1:0] probe_addr;
  logic start;

  dac_probe_t probe [MAX_DEVICES+1];
  logic [MAX_DEVICES-1:0] tok_vec;
  logic [MAX_DEVICES-1:0] occupied;
  logic [MAX_DEVICES-1:0] wr_sel;

  logic req_fire, rsp_fire, cfg_wr, counted, commit, full;
  logic [8:0] fill_w;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD)
                  && (paddr[1:0] == 2'd0);
  assign prdata = (paddr == 3'd0) ? {{24{strength_threshold[7]}}, strength_threshold} : 32'd0;

  assign req_ready = (state == ST_IDLE)
                     && (!rsp_valid || rsp_ready || req.opcode == OP_REPORT);
  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;
  assign counted = (req.opcode == OP_REPORT) && (req.signal_strength >= strength_threshold);

  assign fill_w = 9'(fill_count);
  assign full = fill_w >= 9'(MAX_DEVICES);
  assign commit = (state == ST_SCAN) && probe[MAX_DEVICES].tok && !probe[MAX_DEVICES].hit;

  assign probe[0] = '{tok: start, hit: 1'b0};

  for (genvar i = 0; i < MAX_DEVICES; i++) begin : g_cell
    assign occupied[i] = 9'(i) < fill_w;
    assign wr_sel[i] = commit && !full && (fill_w == 9'(i));
    assign tok_vec[i] = probe[i+1].tok;
    dac_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .occupied   (occupied[i]),
      .wr_sel     (wr_sel[i]),
      .probe_addr (probe_addr),
      .probe_in   (probe[i]),
      .probe_out  (probe[i+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && counted) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (probe[MAX_DEVICES].tok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      probe_addr <= req.device_address;
    end
    if (req_fire && req.opcode == OP_END) begin
      rsp.device_count <= (fill_w > 9'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                   : fill_w[COUNT_W-1:0];
      rsp.table_overflow <= overflow_seen;
    end
    if (rst) begin
      state <= ST_IDLE;
      fill_count <= '0;
      overflow_seen <= 1'b0;
      strength_threshold <= THRESHOLD_RESET;
      start <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      start <= req_fire && counted;
      if (cfg_wr) begin
        strength_threshold <= pwdata[7:0];
      end
      if (req_fire && req.opcode == OP_END) begin
        rsp_valid <= 1'b1;
        fill_count <= '0;
        overflow_seen <= 1'b0;
      end else begin
        if (rsp_fire) begin
          rsp_valid <= 1'b0;
        end
        if (commit) begin
          if (full) begin
            overflow_seen <= 1'b1;
          end else begin
            fill_count <= fill_count + 1'b1;
          end
        end
      end
    end
  end

  a_one_probe: assert property (@(posedge clk) disable iff (rst)
    $onehot0({start, tok_vec}))
    else $error("more than one probe in flight");

  a_exit_in_scan: assert property (@(posedge clk) disable iff (rst)
    probe[MAX_DEVICES].tok |-> state == ST_SCAN)
    else $error("probe left chain outside scan");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_w <= 9'(MAX_DEVICES))
    else $error("fill count beyond table size");

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !req_ready)
    else $error("request accepted during scan");

endmodule
`default_nettype wire
